/* rtl/ffha_pkg.sv */
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REALLOC = 2'd2,
        REQ_CALLOC  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NULL    = 2'd1,
        STAT_NOSPACE = 2'd2,
        STAT_BADADDR = 2'd3
    } status_t;

    // one segment table entry
    typedef struct packed {
        logic        free;
        logic [15:0] size;
        logic [15:0] start;
    } seg_t;

    localparam int unsigned SEG_W = $bits(seg_t);

endpackage

/* rtl/ffha_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module ffha_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// First-fit heap allocator: segment table, sequencer and shared multiplier.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: req_type; tdata: req_size,
//            |     |                              |   elem_count, user_addr
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tuser: status; tdata: result_addr,
//            |     |                              |   copy_src, move_len
//  cfg       | in  | cfg_we                       | cfg_wdata: heap_limit
//
// One request at a time. The table lives in a single RAM with one read and one
// write port, and every walk over it (address lookup, first-fit search, insert
// shift, remove shift, merge pass) steps through each entry in turn: issue read,
// check. A realloc that moves may walk the table up to five times.
// No clearing pass after reset: entries at or above the segment count are never read.
// The finished beat sits in an output register; the next request is taken while it
// waits, and the sequencer stalls in its final state only if a second one is ready.
module first_fit_heap_allocator_top #(
    parameter int unsigned HEAP_BYTES  = 65536,
    parameter int unsigned MAX_SEGS    = 64,
    parameter int unsigned ALIGN_BYTES = 8,
    parameter int unsigned HDR_BYTES   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // req_size, elem_count, user_addr
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // result_addr, copy_src, move_len
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata       // heap_limit
);

    import ffha_pkg::*;

    localparam int unsigned IW = $clog2(MAX_SEGS);
    localparam int unsigned CW = $clog2(MAX_SEGS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGS);

    // usable heap cap, at most the 16-bit address space
    localparam int unsigned HEAP_CAP_I = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
    localparam logic [16:0] HEAP_CAP = 17'(HEAP_CAP_I);

    localparam logic [16:0] HDR17   = 17'(HDR_BYTES);
    localparam logic [17:0] HDR18   = 18'(HDR_BYTES);
    localparam logic [17:0] SPLIT18 = 18'(HDR_BYTES + ALIGN_BYTES);

    // round-up by reciprocal: q = ((n + A - 1) * M) >> K, exact while n + A - 1 < 2^17
    localparam int unsigned RND_L = $clog2(ALIGN_BYTES);
    localparam int unsigned RND_K = 17 + RND_L;
    localparam longint unsigned RND_M =
        ((64'd1 << RND_K) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int unsigned PW = 36;

    typedef enum logic [25:0] {
        S_IDLE    = 26'd1 << 0,
        S_MUL     = 26'd1 << 1,
        S_CHKC    = 26'd1 << 2,
        S_RND1    = 26'd1 << 3,
        S_RND2    = 26'd1 << 4,
        S_RND3    = 26'd1 << 5,
        S_FT_RD   = 26'd1 << 6,
        S_FT_CHK  = 26'd1 << 7,
        S_TAKE    = 26'd1 << 8,
        S_SH_RD   = 26'd1 << 9,
        S_SH_WR   = 26'd1 << 10,
        S_AL_DONE = 26'd1 << 11,
        S_FD_RD   = 26'd1 << 12,
        S_FD_CHK  = 26'd1 << 13,
        S_FREE_W  = 26'd1 << 14,
        S_MG_INIT = 26'd1 << 15,
        S_MG_LD   = 26'd1 << 16,
        S_MG_RD   = 26'd1 << 17,
        S_MG_CHK  = 26'd1 << 18,
        S_RE_CHK  = 26'd1 << 19,
        S_RN_RD   = 26'd1 << 20,
        S_RN_CHK  = 26'd1 << 21,
        S_RN_W2   = 26'd1 << 22,
        S_RM_RD   = 26'd1 << 23,
        S_RM_WR   = 26'd1 << 24,
        S_DONE    = 26'd1 << 25
    } state_t;

    // control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [16:0]    break_reg, break_next;
    logic [16:0]    limit_reg, limit_next;
    logic           mvalid_reg, mvalid_next;

    // request and work registers
    req_type_t      typ_reg, typ_next;
    logic [15:0]    size_reg, size_next;
    logic [15:0]    cnt_reg, cnt_next;
    logic [15:0]    addr_reg, addr_next;
    logic [15:0]    n_reg, n_next;
    logic [16:0]    want_reg, want_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  widx_reg, widx_next;
    logic [CW-1:0]  pos_reg, pos_next;
    seg_t           cur_reg, cur_next;
    seg_t           ins_reg, ins_next;
    logic [15:0]    oldsz_reg, oldsz_next;
    logic           move_reg, move_next;
    logic           rmode_reg, rmode_next;
    logic [15:0]    res_reg, res_next;
    status_t        st_reg, st_next;
    logic [15:0]    src_reg, src_next;
    logic [15:0]    len_reg, len_next;

    // output beat
    logic [15:0]    oaddr_reg, oaddr_next;
    status_t        ost_reg, ost_next;
    logic [15:0]    osrc_reg, osrc_next;
    logic [15:0]    olen_reg, olen_next;

    // table RAM
    logic              we;
    logic [IW-1:0]     waddr, raddr;
    seg_t              wdata, rseg;
    logic [SEG_W-1:0]  rdata;

    // shared multiplier
    logic [16:0]    mul_a;
    logic [18:0]    mul_b;
    logic [PW-1:0]  mul_p;

    // datapath helpers
    logic [16:0]    lim;
    logic [17:0]    need;
    logic [17:0]    split_thr;
    logic [17:0]    comb;
    logic           contig;
    logic [16:0]    q;

    ffha_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGS)
    ) u_tab (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rseg  = seg_t'(rdata);
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign lim       = (limit_reg > HEAP_CAP) ? HEAP_CAP : limit_reg;
    assign need      = HDR18 + {1'b0, want_reg};
    assign split_thr = {1'b0, want_reg} + SPLIT18;
    assign comb      = {2'b00, cur_reg.size} + HDR18 + {2'b00, rseg.size};
    assign contig    = ({1'b0, cur_reg.start} + HDR17 + {1'b0, cur_reg.size})
                       == {1'b0, rseg.start};
    assign q         = 17'(prod_reg >> RND_K);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {olen_reg, osrc_reg, oaddr_reg};
    assign m_axis_tuser  = ost_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        break_next  = break_reg;
        limit_next  = cfg_we ? cfg_wdata : limit_reg;
        mvalid_next = (mvalid_reg && m_axis_tready) ? 1'b0 : mvalid_reg;
        typ_next    = typ_reg;
        size_next   = size_reg;
        cnt_next    = cnt_reg;
        addr_next   = addr_reg;
        n_next      = n_reg;
        want_next   = want_reg;
        prod_next   = prod_reg;
        idx_next    = idx_reg;
        widx_next   = widx_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        ins_next    = ins_reg;
        oldsz_next  = oldsz_reg;
        move_next   = move_reg;
        rmode_next  = rmode_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        src_next    = src_reg;
        len_next    = len_reg;
        oaddr_next  = oaddr_reg;
        ost_next    = ost_reg;
        osrc_next   = osrc_reg;
        olen_next   = olen_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;
        mul_a       = '0;
        mul_b       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    typ_next   = req_type_t'(s_axis_tuser);
                    size_next  = s_axis_tdata[15:0];
                    cnt_next   = s_axis_tdata[31:16];
                    addr_next  = s_axis_tdata[47:32];
                    n_next     = s_axis_tdata[15:0];
                    res_next   = '0;
                    st_next    = STAT_OK;
                    src_next   = '0;
                    len_next   = '0;
                    move_next  = 1'b0;
                    idx_next   = '0;
                    rmode_next = (s_axis_tuser == REQ_REALLOC)
                                 && (s_axis_tdata[47:32] != 16'd0);
                    unique case (req_type_t'(s_axis_tuser))
                        REQ_CALLOC:
                        begin
                            state_next = S_MUL;
                        end
                        REQ_FREE:
                        begin
                            if (s_axis_tdata[47:32] == 16'd0)
                            begin
                                st_next    = STAT_NULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FD_RD;
                            end
                        end
                        REQ_REALLOC:
                        begin
                            if (s_axis_tdata[47:32] != 16'd0)
                            begin
                                state_next = S_FD_RD;
                            end
                            else if (s_axis_tdata[15:0] == 16'd0)
                            begin
                                st_next    = STAT_NULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RND1;
                            end
                        end
                        default:
                        begin
                            if (s_axis_tdata[15:0] == 16'd0)
                            begin
                                st_next    = STAT_NULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RND1;
                            end
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                mul_a      = {1'b0, size_reg};
                mul_b      = {3'b000, cnt_reg};
                prod_next  = mul_p;
                state_next = S_CHKC;
            end

            S_CHKC:
            begin
                if (prod_reg[31:16] != 16'd0)
                begin
                    st_next    = STAT_NOSPACE;
                    state_next = S_DONE;
                end
                else if (prod_reg[15:0] == 16'd0)
                begin
                    st_next    = STAT_NULL;
                    state_next = S_DONE;
                end
                else
                begin
                    n_next     = prod_reg[15:0];
                    state_next = S_RND1;
                end
            end

            S_RND1:
            begin
                mul_a      = {1'b0, n_reg} + 17'(ALIGN_BYTES - 1);
                mul_b      = 19'(RND_M);
                prod_next  = mul_p;
                state_next = S_RND2;
            end

            S_RND2:
            begin
                mul_a      = q;
                mul_b      = 19'(ALIGN_BYTES);
                prod_next  = mul_p;
                state_next = S_RND3;
            end

            S_RND3:
            begin
                want_next = prod_reg[16:0];
                idx_next  = '0;
                state_next = rmode_reg ? S_RE_CHK : S_FT_RD;
            end

            // first-fit walk; append at the break when nothing fits
            S_FT_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    if ((count_reg >= MAXC) || (break_reg > lim)
                        || (need > ({1'b0, lim} - {1'b0, break_reg})))
                    begin
                        res_next   = '0;
                        st_next    = STAT_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        we          = 1'b1;
                        waddr       = IW'(count_reg);
                        wdata.start = break_reg[15:0];
                        wdata.size  = want_reg[15:0];
                        wdata.free  = 1'b0;
                        count_next  = count_reg + CW'(1);
                        break_next  = 17'(need + {1'b0, break_reg});
                        res_next    = 16'({1'b0, break_reg} + HDR17);
                        state_next  = S_AL_DONE;
                    end
                end
                else
                begin
                    raddr      = IW'(idx_reg);
                    state_next = S_FT_CHK;
                end
            end

            S_FT_CHK:
            begin
                if (rseg.free && ({1'b0, rseg.size} >= want_reg))
                begin
                    cur_next   = rseg;
                    pos_next   = idx_reg;
                    state_next = S_TAKE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FT_RD;
                end
            end

            S_TAKE:
            begin
                we          = 1'b1;
                waddr       = IW'(pos_reg);
                wdata.start = cur_reg.start;
                wdata.free  = 1'b0;
                res_next    = 16'({1'b0, cur_reg.start} + HDR17);
                if ((count_reg < MAXC) && ({2'b00, cur_reg.size} >= split_thr))
                begin
                    wdata.size     = want_reg[15:0];
                    ins_next.start = 16'({1'b0, cur_reg.start} + HDR17 + want_reg);
                    ins_next.size  = 16'({2'b00, cur_reg.size} - need);
                    ins_next.free  = 1'b1;
                    idx_next       = count_reg;
                    state_next     = S_SH_RD;
                end
                else
                begin
                    wdata.size = cur_reg.size;
                    state_next = S_AL_DONE;
                end
            end

            // insert shift: move entries up by one, then drop in the new one
            S_SH_RD:
            begin
                if (idx_reg == (pos_reg + CW'(1)))
                begin
                    we         = 1'b1;
                    waddr      = IW'(idx_reg);
                    wdata      = ins_reg;
                    count_next = count_reg + CW'(1);
                    state_next = (rmode_reg && !move_reg) ? S_DONE : S_AL_DONE;
                end
                else
                begin
                    raddr      = IW'(idx_reg - CW'(1));
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                we         = 1'b1;
                waddr      = IW'(idx_reg);
                wdata      = rseg;
                idx_next   = idx_reg - CW'(1);
                state_next = S_SH_RD;
            end

            S_AL_DONE:
            begin
                if (typ_reg == REQ_CALLOC)
                begin
                    len_next = n_reg;
                end
                if (move_reg)
                begin
                    src_next   = addr_reg;
                    len_next   = oldsz_reg;
                    idx_next   = '0;
                    state_next = S_FD_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // lookup of a payload address
            S_FD_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    st_next    = STAT_BADADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = IW'(idx_reg);
                    state_next = S_FD_CHK;
                end
            end

            S_FD_CHK:
            begin
                if (({1'b0, rseg.start} + HDR17) == {1'b0, addr_reg})
                begin
                    cur_next = rseg;
                    pos_next = idx_reg;
                    if (rseg.free)
                    begin
                        st_next    = STAT_BADADDR;
                        state_next = S_DONE;
                    end
                    else if ((typ_reg == REQ_FREE) || move_reg)
                    begin
                        state_next = S_FREE_W;
                    end
                    else if (size_reg == 16'd0)
                    begin
                        st_next    = STAT_NULL;
                        state_next = S_FREE_W;
                    end
                    else
                    begin
                        state_next = S_RND1;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FD_RD;
                end
            end

            S_FREE_W:
            begin
                we          = 1'b1;
                waddr       = IW'(pos_reg);
                wdata       = cur_reg;
                wdata.free  = 1'b1;
                state_next  = S_MG_INIT;
            end

            // merge pass: stream entries, fold free neighbors into cur, compact
            S_MG_INIT:
            begin
                raddr      = '0;
                state_next = S_MG_LD;
            end

            S_MG_LD:
            begin
                cur_next   = rseg;
                idx_next   = CW'(1);
                widx_next  = '0;
                state_next = S_MG_RD;
            end

            S_MG_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    we         = 1'b1;
                    waddr      = IW'(widx_reg);
                    wdata      = cur_reg;
                    count_next = widx_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = IW'(idx_reg);
                    state_next = S_MG_CHK;
                end
            end

            S_MG_CHK:
            begin
                if (cur_reg.free && rseg.free && contig)
                begin
                    cur_next.size = comb[15:0];
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = IW'(widx_reg);
                    wdata     = cur_reg;
                    widx_next = widx_reg + CW'(1);
                    cur_next  = rseg;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_MG_RD;
            end

            // realloc: shrink in place, else try the next neighbor, else move
            S_RE_CHK:
            begin
                if ({1'b0, cur_reg.size} >= want_reg)
                begin
                    res_next = addr_reg;
                    if ((count_reg < MAXC) && ({2'b00, cur_reg.size} >= split_thr))
                    begin
                        we             = 1'b1;
                        waddr          = IW'(pos_reg);
                        wdata.start    = cur_reg.start;
                        wdata.size     = want_reg[15:0];
                        wdata.free     = 1'b0;
                        ins_next.start = 16'({1'b0, cur_reg.start} + HDR17 + want_reg);
                        ins_next.size  = 16'({2'b00, cur_reg.size} - need);
                        ins_next.free  = 1'b1;
                        idx_next       = count_reg;
                        state_next     = S_SH_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_RN_RD;
                end
            end

            S_RN_RD:
            begin
                if ((pos_reg + CW'(1)) >= count_reg)
                begin
                    oldsz_next = cur_reg.size;
                    move_next  = 1'b1;
                    idx_next   = '0;
                    state_next = S_FT_RD;
                end
                else
                begin
                    raddr      = IW'(pos_reg + CW'(1));
                    state_next = S_RN_CHK;
                end
            end

            S_RN_CHK:
            begin
                if (rseg.free && contig && (comb >= {1'b0, want_reg}))
                begin
                    res_next    = addr_reg;
                    we          = 1'b1;
                    waddr       = IW'(pos_reg);
                    wdata.start = cur_reg.start;
                    wdata.free  = 1'b0;
                    if (comb >= split_thr)
                    begin
                        wdata.size     = want_reg[15:0];
                        ins_next.start = 16'({1'b0, cur_reg.start} + HDR17 + want_reg);
                        ins_next.size  = 16'(comb - need);
                        ins_next.free  = 1'b1;
                        state_next     = S_RN_W2;
                    end
                    else
                    begin
                        wdata.size = comb[15:0];
                        idx_next   = pos_reg + CW'(1);
                        state_next = S_RM_RD;
                    end
                end
                else
                begin
                    oldsz_next = cur_reg.size;
                    move_next  = 1'b1;
                    idx_next   = '0;
                    state_next = S_FT_RD;
                end
            end

            S_RN_W2:
            begin
                we         = 1'b1;
                waddr      = IW'(pos_reg + CW'(1));
                wdata      = ins_reg;
                state_next = S_DONE;
            end

            // remove shift: move entries down by one
            S_RM_RD:
            begin
                if ((idx_reg + CW'(1)) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = IW'(idx_reg + CW'(1));
                    state_next = S_RM_WR;
                end
            end

            S_RM_WR:
            begin
                we         = 1'b1;
                waddr      = IW'(idx_reg);
                wdata      = rseg;
                idx_next   = idx_reg + CW'(1);
                state_next = S_RM_RD;
            end

            S_DONE:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    oaddr_next  = res_reg;
                    ost_next    = st_reg;
                    osrc_next   = src_reg;
                    olen_next   = len_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            break_reg  <= '0;
            limit_reg  <= 17'h10000;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            break_reg  <= break_next;
            limit_reg  <= limit_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        typ_reg   <= typ_next;
        size_reg  <= size_next;
        cnt_reg   <= cnt_next;
        addr_reg  <= addr_next;
        n_reg     <= n_next;
        want_reg  <= want_next;
        prod_reg  <= prod_next;
        idx_reg   <= idx_next;
        widx_reg  <= widx_next;
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        ins_reg   <= ins_next;
        oldsz_reg <= oldsz_next;
        move_reg  <= move_next;
        rmode_reg <= rmode_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        src_reg   <= src_next;
        len_reg   <= len_next;
        oaddr_reg <= oaddr_next;
        ost_reg   <= ost_next;
        osrc_reg  <= osrc_next;
        olen_reg  <= olen_next;
    end

`ifndef SYNTHESIS
    // table never holds more segments than it has room for
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("segment count above table depth");

    // the table grows by at most one segment per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= ({1'b0, $past(count_reg)} + (CW+1)'(1)))
        else $error("segment count jumped");

    // a result beat is only raised from the final state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside final state");
`endif

endmodule
